FILE: rtl/core/adsr_env_pkg.sv
// Shared types, constants and microcode ROM for the stereo ADSR envelope.
// No dependencies; used by adsr_env_div and adsr_envelope_stereo in rtl/core.
package adsr_env_pkg;

    localparam int REG_W     = 20;      // config register width
    localparam int T_W       = 21;      // elapsed sample counter width
    localparam int NUM_W     = 20;      // gain numerator width
    localparam int DEN_W     = 21;      // gain denominator width
    localparam int SMP_W     = 16;      // audio sample width
    localparam int CMP_W     = 23;      // signed width for segment compares
    localparam int PROD_W    = SMP_W + NUM_W;
    localparam int DIV_ITERS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_ITERS);
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    localparam logic [REG_W-1:0] DURATION_RST = REG_W'(4410);
    localparam logic [REG_W-1:0] ATTACK_RST   = REG_W'(1323);
    localparam logic [REG_W-1:0] DECAY_RST    = REG_W'(882);
    localparam logic [REG_W-1:0] SUSTAIN_RST  = REG_W'(1323);
    localparam logic [REG_W-1:0] RELEASE_RST  = REG_W'(882);

    // register indexes (byte address / 4)
    localparam logic [2:0] IDX_DURATION = 3'd0;
    localparam logic [2:0] IDX_ATTACK   = 3'd1;
    localparam logic [2:0] IDX_DECAY    = 3'd2;
    localparam logic [2:0] IDX_SUSTAIN  = 3'd3;
    localparam logic [2:0] IDX_RELEASE  = 3'd4;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } cond_t;

    // program steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEL,
        ST_MUL_L,
        ST_MUL_R,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_FIN,
        ST_RET
    } step_t;

    typedef struct packed {
        logic  in_rdy;
        logic  prep;
        logic  sel;
        logic  mul_l;
        logic  mul_r;
        logic  div_init;
        logic  div_step;
        logic  out_ld;
        cond_t cond;
        step_t target;
    } ucw_t;

    typedef struct packed {
        logic init;
        logic step;
    } div_ctl_t;

    // control store: one word per step, jump to target when cond holds
    function automatic ucw_t ucode(input step_t s);
        ucw_t w;
        begin
            w        = '0;
            w.cond   = COND_NEVER;
            w.target = ST_IDLE;
            case (s)
                ST_IDLE:
                begin
                    w.in_rdy = 1'b1;
                    w.cond   = COND_NO_IN;
                    w.target = ST_IDLE;
                end
                ST_PREP:     w.prep     = 1'b1;
                ST_SEL:      w.sel      = 1'b1;
                ST_MUL_L:    w.mul_l    = 1'b1;
                ST_MUL_R:    w.mul_r    = 1'b1;
                ST_DIV_INIT: w.div_init = 1'b1;
                ST_DIV_STEP:
                begin
                    w.div_step = 1'b1;
                    w.cond     = COND_DIV_BUSY;
                    w.target   = ST_DIV_STEP;
                end
                ST_FIN:
                begin
                    w.out_ld = 1'b1;
                    w.cond   = COND_OUT_FULL;
                    w.target = ST_FIN;
                end
                ST_RET:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = ST_IDLE;
                end
                default:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = ST_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/core/adsr_env_div.sv
// One lane of the restoring divider: one quotient bit per step.
// Depends on adsr_env_pkg (widths, div_ctl_t).
module adsr_env_div (
    input  logic                                clk,
    input  adsr_env_pkg::div_ctl_t              ctl,
    input  logic [adsr_env_pkg::PROD_W-1:0]     dividend,
    input  logic [adsr_env_pkg::DEN_W-1:0]      divisor,
    output logic [adsr_env_pkg::PROD_W-1:0]     quotient
);

    logic [adsr_env_pkg::PROD_W-1:0] q_reg, q_next;
    logic [adsr_env_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [adsr_env_pkg::DEN_W:0]    rem_sh, diff;
    logic                            fits;

    always_comb
    begin
        rem_sh = {rem_reg, q_reg[adsr_env_pkg::PROD_W-1]};
        diff   = rem_sh - {1'b0, divisor};
        fits   = (rem_sh >= {1'b0, divisor});
        q_next   = q_reg;
        rem_next = rem_reg;
        if (ctl.init)
        begin
            q_next   = dividend;
            rem_next = '0;
        end
        else if (ctl.step)
        begin
            q_next   = {q_reg[adsr_env_pkg::PROD_W-2:0], fits};
            rem_next = fits ? diff[adsr_env_pkg::DEN_W-1:0]
                            : rem_sh[adsr_env_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient = q_reg;

endmodule

FILE: rtl/core/adsr_envelope_stereo.sv
// Top level of the stereo ADSR envelope: APB register file, microcoded
// sequencer, shared multiplier and two divider lanes.
// Depends on adsr_env_pkg and adsr_env_div.

// Scales each stereo beat by a piecewise-linear envelope of the elapsed
// sample count t (attack ramp, decay ramp, sustain level, release ramp,
// else unity), computed exactly as sample * num / den truncated toward zero
// and saturated to 16 bits. Beats are processed one at a time: after a beat
// is accepted the sequencer steps through prep, select, left and right
// multiply, divide init, the 36-iteration restoring divide (both channels
// divide side by side, one quotient bit per clock), output load and return
// before it accepts the next beat. The result register lets the next beat
// be accepted while a result waits for m_axis_tready. tuser carries the
// restart flag, which zeroes t before the beat; tlast flags the beat after
// which t reaches duration_len. t stops at its maximum rather than
// wrapping. Registers (20 bits, byte address 4*i): duration, attack, decay,
// sustain, release; writes at other addresses are dropped. Outputs are
// zero when release+decay is zero or t has reached duration.
module adsr_envelope_stereo (
    input  logic                               clk,
    input  logic                               rst_n,
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adsr_env_pkg::ADDR_W-1:0]    paddr,
    input  logic [adsr_env_pkg::DATA_W-1:0]    pwdata,
    output logic [adsr_env_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // left_in, right_in
    input  logic                               s_axis_tuser,  // restart
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // left_out, right_out
    output logic                               m_axis_tlast   // note_done
);

    localparam int RW = adsr_env_pkg::REG_W;
    localparam int TW = adsr_env_pkg::T_W;
    localparam int CW = adsr_env_pkg::CMP_W;
    localparam int SW = adsr_env_pkg::SMP_W;
    localparam int NW = adsr_env_pkg::NUM_W;
    localparam int DW = adsr_env_pkg::DEN_W;
    localparam int PW = adsr_env_pkg::PROD_W;

    // ---------------- config registers ----------------
    logic [RW-1:0] dur_reg, att_reg, dec_reg, sus_reg, rel_reg;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= adsr_env_pkg::DURATION_RST;
            att_reg <= adsr_env_pkg::ATTACK_RST;
            dec_reg <= adsr_env_pkg::DECAY_RST;
            sus_reg <= adsr_env_pkg::SUSTAIN_RST;
            rel_reg <= adsr_env_pkg::RELEASE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                adsr_env_pkg::IDX_DURATION: dur_reg <= pwdata[RW-1:0];
                adsr_env_pkg::IDX_ATTACK:   att_reg <= pwdata[RW-1:0];
                adsr_env_pkg::IDX_DECAY:    dec_reg <= pwdata[RW-1:0];
                adsr_env_pkg::IDX_SUSTAIN:  sus_reg <= pwdata[RW-1:0];
                adsr_env_pkg::IDX_RELEASE:  rel_reg <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            adsr_env_pkg::IDX_DURATION: prdata = 32'(dur_reg);
            adsr_env_pkg::IDX_ATTACK:   prdata = 32'(att_reg);
            adsr_env_pkg::IDX_DECAY:    prdata = 32'(dec_reg);
            adsr_env_pkg::IDX_SUSTAIN:  prdata = 32'(sus_reg);
            adsr_env_pkg::IDX_RELEASE:  prdata = 32'(rel_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    adsr_env_pkg::step_t pc_reg, pc_next;
    adsr_env_pkg::ucw_t  uc;
    logic [adsr_env_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_full, jump;
    logic in_acc, out_ld;

    // control word outputs
    always_comb
    begin
        uc = adsr_env_pkg::ucode(pc_reg);
    end

    assign out_full = out_valid_reg && !m_axis_tready;
    assign s_axis_tready = uc.in_rdy;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_ld = uc.out_ld && !out_full;

    // next step
    always_comb
    begin
        case (uc.cond)
            adsr_env_pkg::COND_NEVER:    jump = 1'b0;
            adsr_env_pkg::COND_ALWAYS:   jump = 1'b1;
            adsr_env_pkg::COND_NO_IN:    jump = !s_axis_tvalid;
            adsr_env_pkg::COND_DIV_BUSY: jump = (cnt_reg != '0);
            adsr_env_pkg::COND_OUT_FULL: jump = out_full;
            default:                     jump = 1'b1;
        endcase
        pc_next = jump ? uc.target : adsr_env_pkg::step_t'(pc_reg + 4'd1);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (uc.div_init)
            cnt_next = adsr_env_pkg::CNT_W'(adsr_env_pkg::DIV_ITERS - 1);
        else if (uc.div_step)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= adsr_env_pkg::ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    // ---------------- datapath ----------------
    logic                 restart_reg;
    logic signed [SW-1:0] left_reg, right_reg;
    logic [TW-1:0]        t_reg;

    // derived segment bounds (prep step)
    logic signed [CW-1:0] dmrs_reg, dmr_reg, dms_reg;
    logic [DW-1:0]        apd_reg, den_sum_reg;

    // gain and magnitudes (select step)
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] mag_l_reg, mag_r_reg;
    logic          neg_l_reg, neg_r_reg, done_reg;
    logic [PW-1:0] prod_l_reg, prod_r_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            restart_reg <= s_axis_tuser;
            left_reg    <= s_axis_tdata[15:0];
            right_reg   <= s_axis_tdata[31:16];
        end
    end

    logic signed [CW-1:0] d_s, r_s, s_s;
    assign d_s = $signed({3'b0, dur_reg});
    assign r_s = $signed({3'b0, rel_reg});
    assign s_s = $signed({3'b0, sus_reg});

    always_ff @(posedge clk)
    begin
        if (uc.prep)
        begin
            dmrs_reg    <= d_s - r_s - s_s;
            dmr_reg     <= d_s - r_s;
            dms_reg     <= d_s - s_s;
            apd_reg     <= {1'b0, att_reg} + {1'b0, dec_reg};
            den_sum_reg <= {1'b0, rel_reg} + {1'b0, dec_reg};
        end
    end

    // segment choice, first match wins
    logic signed [CW-1:0] t_s, dec_num;
    logic [TW-1:0]        t_inc, rel_num;
    logic                 seg_zero, seg_att, seg_dec, seg_sus, seg_rel;
    logic [NW-1:0]        num_sel;
    logic [DW-1:0]        den_sel;

    always_comb
    begin
        t_s      = $signed({2'b0, t_reg});
        dec_num  = dms_reg - t_s;
        rel_num  = {1'b0, dur_reg} - t_reg;
        seg_zero = (den_sum_reg == '0) || (t_reg >= {1'b0, dur_reg});
        seg_att  = (t_reg < {1'b0, att_reg});
        seg_dec  = (t_reg > {1'b0, att_reg}) && (t_s < dmrs_reg);
        seg_sus  = (t_reg > apd_reg) && (t_s < dmr_reg);
        seg_rel  = (t_s > dmr_reg);
        den_sel  = den_sum_reg;
        if (seg_zero)
        begin
            num_sel = '0;
            den_sel = DW'(1);
        end
        else if (seg_att)
        begin
            num_sel = t_reg[NW-1:0];
            den_sel = {1'b0, att_reg};
        end
        else if (seg_dec)
            num_sel = dec_num[NW-1:0];
        else if (seg_sus)
            num_sel = dec_reg;
        else if (seg_rel)
            num_sel = rel_num[NW-1:0];
        else
        begin
            // unity gain
            num_sel = NW'(1);
            den_sel = DW'(1);
        end
        t_inc = (t_reg == adsr_env_pkg::T_MAX) ? t_reg : t_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= '0;
        else if (uc.prep && restart_reg)
            t_reg <= '0;
        else if (uc.sel)
            t_reg <= t_inc;
    end

    always_ff @(posedge clk)
    begin
        if (uc.sel)
        begin
            num_reg   <= num_sel;
            den_reg   <= den_sel;
            neg_l_reg <= left_reg[SW-1];
            neg_r_reg <= right_reg[SW-1];
            mag_l_reg <= left_reg[SW-1] ? (~left_reg + 1'b1) : left_reg;
            mag_r_reg <= right_reg[SW-1] ? (~right_reg + 1'b1) : right_reg;
            done_reg  <= (t_inc >= {1'b0, dur_reg});
        end
    end

    // one multiplier, left then right
    logic [PW-1:0] mul_p;
    assign mul_p = PW'(uc.mul_l ? mag_l_reg : mag_r_reg) * PW'(num_reg);

    always_ff @(posedge clk)
    begin
        if (uc.mul_l)
            prod_l_reg <= mul_p;
        if (uc.mul_r)
            prod_r_reg <= mul_p;
    end

    // divider lanes
    adsr_env_pkg::div_ctl_t div_ctl;
    logic [PW-1:0] quo_l, quo_r;

    assign div_ctl.init = uc.div_init;
    assign div_ctl.step = uc.div_step;

    adsr_env_div u_div_l (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (prod_l_reg),
        .divisor  (den_reg),
        .quotient (quo_l)
    );

    adsr_env_div u_div_r (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (prod_r_reg),
        .divisor  (den_reg),
        .quotient (quo_r)
    );

    // apply sign and clamp to 16 bits
    function automatic logic [SW-1:0] sat_sign(input logic [PW-1:0] q, input logic neg);
        logic [SW-1:0] r;
        begin
            if (neg)
            begin
                if (q >= PW'(32768))
                    r = 16'h8000;
                else
                    r = ~q[SW-1:0] + 1'b1;
            end
            else
            begin
                if (q > PW'(32767))
                    r = 16'h7FFF;
                else
                    r = q[SW-1:0];
            end
            return r;
        end
    endfunction

    // ---------------- output register ----------------
    logic [SW-1:0] out_l_reg, out_r_reg;
    logic          out_last_reg;

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            out_l_reg    <= sat_sign(quo_l, neg_l_reg);
            out_r_reg    <= sat_sign(quo_r, neg_r_reg);
            out_last_reg <= done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ld)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_r_reg, out_l_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/core/adsr_env_chk.sv
// Port-level checker for adsr_envelope_stereo, with its bind statement.
// Depends on adsr_envelope_stereo's port list only.
module adsr_env_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    // one beat in flight: input ready stays low after an accepted beat
    a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready again too soon after a beat");

    // a fresh result is never loaded while the input side is open
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while sequencer idle");

    // a result never appears directly after its own input beat
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |=> !$rose(m_axis_tvalid))
        else $error("result appeared right after input beat");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

endmodule

bind adsr_envelope_stereo adsr_env_chk u_adsr_env_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
